### hdl/rwcl_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk locator.
package rwcl_pkg;

  // Four-character codes as little-endian 32-bit words.
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  // Reset value of the minimum fmt chunk length register.
  localparam logic [7:0] MinFormatLengthReset = 8'd14;

  // Reported parse status.
  typedef enum logic [1:0] {
    ST_PARSING = 2'd0,
    ST_FOUND   = 2'd1,
    ST_FAILED  = 2'd2
  } status_e;

  // Parse phase, one-hot.
  typedef enum logic [6:0] {
    PH_RIFF = 7'b000_0001,
    PH_RLEN = 7'b000_0010,
    PH_WAVE = 7'b000_0100,
    PH_CTAG = 7'b000_1000,
    PH_CLEN = 7'b001_0000,
    PH_BODY = 7'b010_0000,
    PH_DONE = 7'b100_0000
  } phase_e;

  // One input item.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    status_e     parse_status;
    logic [31:0] format_offset;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

endpackage

### hdl/rwcl_parser.sv
// Parse state registers and the per-byte next-state logic of the chunk locator.
module rwcl_parser import rwcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  item_t      item_i,
  input  logic [7:0] min_len_i,
  output result_t    res_o
);

  logic [31:0] pos_q, pos_d;
  logic [31:0] word_q, word_d;
  phase_e      phase_q, phase_d;
  logic [31:0] tag_q, tag_d;
  logic [32:0] skip_q, skip_d;
  logic [32:0] end_q, end_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic [31:0] fmt_off_q, fmt_off_d;
  logic [31:0] data_off_q, data_off_d;
  logic [31:0] data_size_q, data_size_d;
  status_e     status_q, status_d;

  // State as seen by this item: a first byte restarts from the cleared state.
  logic        restart;
  logic [31:0] cur_pos;
  logic [31:0] cur_word;
  phase_e      cur_phase;
  logic [31:0] cur_tag;
  logic [32:0] cur_skip;
  logic [32:0] cur_end;
  logic        cur_fmt_seen;
  logic        cur_data_seen;
  logic [31:0] cur_fmt_off;
  logic [31:0] cur_data_off;
  logic [31:0] cur_data_size;
  status_e     cur_status;

  assign restart       = item_i.first_byte;
  assign cur_pos       = restart ? '0 : pos_q;
  assign cur_word      = restart ? '0 : word_q;
  assign cur_phase     = restart ? PH_RIFF : phase_q;
  assign cur_tag       = restart ? '0 : tag_q;
  assign cur_skip      = restart ? '0 : skip_q;
  assign cur_end       = restart ? '0 : end_q;
  assign cur_fmt_seen  = restart ? 1'b0 : fmt_seen_q;
  assign cur_data_seen = restart ? 1'b0 : data_seen_q;
  assign cur_fmt_off   = restart ? '0 : fmt_off_q;
  assign cur_data_off  = restart ? '0 : data_off_q;
  assign cur_data_size = restart ? '0 : data_size_q;
  assign cur_status    = restart ? ST_PARSING : status_q;

  // Shared arithmetic for this byte.
  logic [31:0] pos_inc;
  logic [31:0] word_new;
  logic [32:0] skip_dec;
  logic [32:0] pad_len;
  logic        past_end;
  logic        word_full;
  logic        fmt_first;
  logic        data_first;

  assign pos_inc    = cur_pos + 32'd1;
  assign word_new   = {item_i.byte_value, cur_word[31:8]};
  assign skip_dec   = cur_skip - 33'd1;
  assign pad_len    = ({1'b0, word_new} + 33'd1) & ~33'd1;
  assign past_end   = ({1'b0, pos_inc} >= cur_end);
  assign word_full  = (cur_skip[1:0] == 2'd3);
  assign fmt_first  = (cur_tag == TagFmt) && !cur_fmt_seen;
  assign data_first = (cur_tag == TagData) && !cur_data_seen;

  // Next-state logic for one byte.
  always_comb begin
    pos_d       = cur_pos;
    word_d      = cur_word;
    phase_d     = cur_phase;
    tag_d       = cur_tag;
    skip_d      = cur_skip;
    end_d       = cur_end;
    fmt_seen_d  = cur_fmt_seen;
    data_seen_d = cur_data_seen;
    fmt_off_d   = cur_fmt_off;
    data_off_d  = cur_data_off;
    data_size_d = cur_data_size;
    status_d    = cur_status;

    if (cur_phase == PH_BODY) begin
      // Skip one body byte; at the end of the body a chunk header may start.
      pos_d  = pos_inc;
      skip_d = skip_dec;
      if (skip_dec == '0) begin
        if (past_end) begin
          status_d = ST_FAILED;
          phase_d  = PH_DONE;
        end else begin
          phase_d = PH_CTAG;
        end
      end
    end else if (cur_phase != PH_DONE) begin
      // Header phases: shift the byte into the word being built.
      pos_d  = pos_inc;
      word_d = word_new;
      skip_d = cur_skip + 33'd1;
      if (word_full) begin
        skip_d = '0;
        unique case (cur_phase)
          PH_RIFF: begin
            if (word_new != TagRiff) begin
              status_d = ST_FAILED;
              phase_d  = PH_DONE;
            end else begin
              phase_d = PH_RLEN;
            end
          end
          PH_RLEN: begin
            end_d   = 33'd8 + {1'b0, word_new};
            phase_d = PH_WAVE;
          end
          PH_WAVE: begin
            if (word_new != TagWave || past_end) begin
              status_d = ST_FAILED;
              phase_d  = PH_DONE;
            end else begin
              phase_d = PH_CTAG;
            end
          end
          PH_CTAG: begin
            tag_d   = word_new;
            phase_d = PH_CLEN;
          end
          default: begin
            // Chunk length: check fmt minimum, record first fmt and data chunks.
            if (fmt_first && (word_new < {24'd0, min_len_i})) begin
              status_d = ST_FAILED;
              phase_d  = PH_DONE;
            end else if (fmt_first && cur_data_seen) begin
              fmt_seen_d = 1'b1;
              fmt_off_d  = pos_inc;
              status_d   = ST_FOUND;
              phase_d    = PH_DONE;
            end else if (data_first && cur_fmt_seen) begin
              data_seen_d = 1'b1;
              data_off_d  = pos_inc;
              data_size_d = word_new;
              status_d    = ST_FOUND;
              phase_d     = PH_DONE;
            end else begin
              if (fmt_first) begin
                fmt_seen_d = 1'b1;
                fmt_off_d  = pos_inc;
              end else if (data_first) begin
                data_seen_d = 1'b1;
                data_off_d  = pos_inc;
                data_size_d = word_new;
              end
              skip_d = pad_len;
              if (pad_len != '0) begin
                phase_d = PH_BODY;
              end else if (past_end) begin
                status_d = ST_FAILED;
                phase_d  = PH_DONE;
              end else begin
                phase_d = PH_CTAG;
              end
            end
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      status_q    <= ST_PARSING;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      pos_q       <= '0;
      word_q      <= '0;
      tag_q       <= '0;
      skip_q      <= '0;
      end_q       <= '0;
      fmt_off_q   <= '0;
      data_off_q  <= '0;
      data_size_q <= '0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      status_q    <= status_d;
      fmt_seen_q  <= fmt_seen_d;
      data_seen_q <= data_seen_d;
      pos_q       <= pos_d;
      word_q      <= word_d;
      tag_q       <= tag_d;
      skip_q      <= skip_d;
      end_q       <= end_d;
      fmt_off_q   <= fmt_off_d;
      data_off_q  <= data_off_d;
      data_size_q <= data_size_d;
    end
  end

  // The stored values are the result of the last item.
  assign res_o.parse_status  = status_q;
  assign res_o.format_offset = fmt_off_q;
  assign res_o.data_offset   = data_off_q;
  assign res_o.data_size     = data_size_q;

  // A final status and the finished phase always go together.
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) == (status_q != ST_PARSING))
    else $error("finished phase and status disagree");

  // In a body there is always at least one byte left to skip.
  a_body_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (skip_q != '0))
    else $error("body phase with nothing to skip");

  // Outside a body the skip counter only counts word bytes.
  a_hdr_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_BODY) |-> (skip_q[32:2] == '0))
    else $error("header byte count out of range");

  // Data size stays clear until the data chunk is found.
  a_data_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !data_seen_q |-> (data_size_q == '0 && data_off_q == '0))
    else $error("data fields set before the data chunk");

  // Without an advancing item the parse position holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(pos_q) && $stable(phase_q))
    else $error("parse state moved without an item");

endmodule

### hdl/riff_wave_chunk_locator_unit.sv
// Top level of the RIFF/WAVE chunk locator: input register, parser, result handshake.
//
//  Channel  Direction  Handshake                     Payload
//  in       input      in_valid_i / in_stall_o       byte_value_i, first_byte_i
//  out      output     out_valid_o / out_stall_i     parse_status_o, format_offset_o,
//                                                    data_offset_o, data_size_o
//  cfg      input      cfg_valid_i / cfg_ready_o     min_format_length_i
//
// Every input item yields one result item once the parser advances on it.
// One item is accepted per cycle unless stalled; the parse registers form a loop.
// Reset clears the parse to the RIFF tag phase and sets the fmt minimum to 14.
// A stalled result holds the parse state, and the input register fills and
// then stalls the input channel.
module riff_wave_chunk_locator_unit import rwcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  parse_status_o,
  output logic [31:0] format_offset_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] data_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  min_format_length_i
);

  logic       in_valid_q;
  item_t      in_item_q;
  logic       out_valid_q;
  logic       advance;
  logic [7:0] min_len_q;
  result_t    res;

  // The parser advances when an item is held and the result slot is free.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q.byte_value <= byte_value_i;
      in_item_q.first_byte <= first_byte_i;
    end
  end

  // Result valid flag; the payload lives in the parser's stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Minimum fmt chunk length register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinFormatLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_len_q <= min_format_length_i;
    end
  end

  rwcl_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .item_i    (in_item_q),
    .min_len_i (min_len_q),
    .res_o     (res)
  );

  assign out_valid_o     = out_valid_q;
  assign parse_status_o  = res.parse_status;
  assign format_offset_o = res.format_offset;
  assign data_offset_o   = res.data_offset;
  assign data_size_o     = res.data_size;

endmodule
